### src/fpa_pkg.sv
`default_nettype none
package fpa_pkg;

    localparam int PAGE_W          = 52;
    localparam int LEN_W           = 21;
    localparam int MAX_EXTENTS_DEF = 64;

    localparam logic [LEN_W-1:0]  LEN_MAX     = {LEN_W{1'b1}};
    localparam logic [PAGE_W-1:0] FIRST_RESET = '0;
    localparam logic [LEN_W-1:0]  TOTAL_RESET = LEN_W'(256);

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_FIT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic CFG_FIRST = 1'b0;
    localparam logic CFG_TOTAL = 1'b1;

    typedef struct packed {
        logic [PAGE_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } t_extent;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_JNEXT,
        S_JPREV,
        S_WRITE,
        S_SHIFT,
        S_RESP
    } t_state;

    // Length of a region cut so that it ends no later than the top of page space.
    function automatic logic [LEN_W-1:0] clip_len(input logic [PAGE_W-1:0] page,
                                                  input logic [LEN_W-1:0] count);
        logic [PAGE_W:0] room;
        room = {1'b1, {PAGE_W{1'b0}}} - {1'b0, page};
        if ({{(PAGE_W+1-LEN_W){1'b0}}, count} > room) begin
            clip_len = room[LEN_W-1:0];
        end else begin
            clip_len = count;
        end
    endfunction

endpackage
`default_nettype wire

### src/first_fit_page_allocator.sv
// First-fit page allocator. The free extents live in one table memory, sorted by start
// page, with one read and one write port. A request scans the table one entry per cycle
// from the front and stops at the first entry that decides it. An allocation that
// removes an exact fit, or a free that inserts a new extent or merges one away, then
// moves the entries behind it one per cycle. A held result stalls the next word once
// the output register is full. A write of either configuration register reloads the
// table in the same cycle with one extent covering the heap, or none if it is empty.
`default_nettype none
module first_fit_page_allocator
    import fpa_pkg::*;
#(
    parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_func,
    input  wire logic [LEN_W-1:0]  i_page_count,
    input  wire logic [PAGE_W-1:0] i_free_page,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [1:0]             o_status,
    output logic [PAGE_W-1:0]      o_granted_page,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [PAGE_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);

    t_extent mem [MAX_EXTENTS];

    t_state            r_state, n_state;
    logic [CW-1:0]     r_used;
    logic [PAGE_W-1:0] r_first;
    logic [LEN_W-1:0]  r_total;
    logic              r_out_valid;
    logic [1:0]        r_o_status;
    logic [PAGE_W-1:0] r_o_granted;

    logic              r_op;
    logic [LEN_W-1:0]  r_count;
    logic [PAGE_W-1:0] r_page;
    logic [LEN_W-1:0]  r_len;
    logic [1:0]        r_status;
    logic [PAGE_W-1:0] r_granted;
    logic [CW-1:0]     r_pos;
    t_extent           r_prev, r_next;
    logic              r_has_prev, r_has_next;
    logic              r_join_next;
    logic [LEN_W-1:0]  r_merged;
    logic [AW-1:0]     r_src, r_last, r_chk;
    logic              r_up, r_iss_done, r_dv;
    logic              r_then_write, r_then_shift;
    logic [AW-1:0]     r_wr_addr;
    t_extent           r_wr_data;
    t_extent           r_rdata;

    logic              w_accept, w_out_take, w_load, w_issue;
    logic [PAGE_W-1:0] w_ld_first;
    logic [LEN_W-1:0]  w_ld_total, w_ld_len, w_in_len;
    logic              w_a_hit, w_a_exact, w_a_shift, w_f_next, w_scan_end;
    logic              w_jn, w_jp, w_rm_shift, w_ins_shift, w_full;
    logic [LEN_W:0]    w_jn_sum, w_jp_sum;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    t_extent           w_wdata;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_take = r_out_valid && i_out_ready;
    assign w_in_len   = clip_len(i_free_page, i_page_count);

    assign w_load     = !i_rst_n || i_cfg_we;
    assign w_ld_first = !i_rst_n ? FIRST_RESET :
                        (i_cfg_index == CFG_FIRST) ? i_cfg_data : r_first;
    assign w_ld_total = !i_rst_n ? TOTAL_RESET :
                        (i_cfg_index == CFG_TOTAL) ? i_cfg_data[LEN_W-1:0] : r_total;
    assign w_ld_len   = clip_len(w_ld_first, w_ld_total);

    assign w_a_hit    = r_rdata.len >= r_count;
    assign w_a_exact  = r_rdata.len == r_count;
    assign w_a_shift  = (CW'(r_chk) + CW'(1)) < r_used;
    assign w_f_next   = r_rdata.start > r_page;
    assign w_scan_end = r_iss_done && !r_dv;

    assign w_jn_sum   = {1'b0, r_len} + {1'b0, r_next.len};
    assign w_jn       = r_has_next
                        && (({1'b0, r_page} + {{(PAGE_W+1-LEN_W){1'b0}}, r_len})
                            == {1'b0, r_next.start})
                        && (w_jn_sum <= {1'b0, LEN_MAX});
    assign w_jp_sum   = {1'b0, r_prev.len} + {1'b0, r_merged};
    assign w_jp       = r_has_prev
                        && (({1'b0, r_prev.start} + {{(PAGE_W+1-LEN_W){1'b0}}, r_prev.len})
                            == {1'b0, r_page})
                        && (w_jp_sum <= {1'b0, LEN_MAX});
    assign w_rm_shift  = r_join_next && ((r_pos + CW'(1)) < r_used);
    assign w_ins_shift = r_pos < r_used;
    assign w_full      = r_used == CW'(MAX_EXTENTS);

    assign w_issue = !r_iss_done && ((r_state == S_SCAN) || (r_state == S_SHIFT))
                     && (n_state == r_state);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_func == FUNC_ALLOC) begin
                        n_state = (i_page_count == '0) ? S_RESP : S_SCAN;
                    end else begin
                        n_state = (w_in_len == '0) ? S_RESP : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_dv && (r_op == FUNC_ALLOC) && w_a_hit) begin
                    if (!w_a_exact) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = w_a_shift ? S_SHIFT : S_RESP;
                    end
                end else if (r_dv && (r_op == FUNC_FREE) && w_f_next) begin
                    n_state = S_JNEXT;
                end else if (w_scan_end) begin
                    n_state = (r_op == FUNC_ALLOC) ? S_RESP : S_JNEXT;
                end
            end
            S_JNEXT: n_state = S_JPREV;
            S_JPREV: begin
                if (w_jp || r_join_next) begin
                    n_state = S_WRITE;
                end else if (w_full) begin
                    n_state = S_RESP;
                end else begin
                    n_state = w_ins_shift ? S_SHIFT : S_WRITE;
                end
            end
            S_WRITE: n_state = r_then_shift ? S_SHIFT : S_RESP;
            S_SHIFT: begin
                if (w_scan_end) begin
                    n_state = r_then_write ? S_WRITE : S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = r_state == S_IDLE;
        w_we       = 1'b0;
        w_waddr    = '0;
        w_wdata    = r_rdata;
        if (w_load) begin
            w_we    = 1'b1;
            w_wdata = '{start: w_ld_first, len: w_ld_len};
        end else if (r_state == S_WRITE) begin
            w_we    = 1'b1;
            w_waddr = r_wr_addr;
            w_wdata = r_wr_data;
        end else if ((r_state == S_SHIFT) && r_dv) begin
            w_we    = 1'b1;
            w_waddr = r_up ? (r_chk + AW'(1)) : (r_chk - AW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[r_src];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= CW'(w_ld_len != '0);
            r_first     <= FIRST_RESET;
            r_total     <= TOTAL_RESET;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
            r_iss_done  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_dv    <= w_issue;
            r_chk   <= r_src;
            if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FIRST) begin
                    r_first <= i_cfg_data;
                end else begin
                    r_total <= i_cfg_data[LEN_W-1:0];
                end
                r_used <= CW'(w_ld_len != '0);
            end
            if (w_issue) begin
                if (r_src == r_last) begin
                    r_iss_done <= 1'b1;
                end else begin
                    r_src <= r_up ? (r_src - AW'(1)) : (r_src + AW'(1));
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op       <= i_func;
                        r_count    <= i_page_count;
                        r_page     <= i_free_page;
                        r_len      <= w_in_len;
                        r_granted  <= '0;
                        r_status   <= (i_func == FUNC_ALLOC) ? ST_NO_FIT : ST_OK;
                        r_src      <= '0;
                        r_last     <= AW'(r_used - CW'(1));
                        r_up       <= 1'b0;
                        r_iss_done <= r_used == '0;
                        r_has_prev <= 1'b0;
                        r_has_next <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (r_dv && (r_op == FUNC_ALLOC) && w_a_hit) begin
                        r_status  <= ST_OK;
                        r_granted <= r_rdata.start;
                        r_wr_addr <= r_chk;
                        r_wr_data <= '{start: r_rdata.start + PAGE_W'(r_count),
                                       len: r_rdata.len - r_count};
                        r_then_shift <= 1'b0;
                        if (w_a_exact) begin
                            r_used       <= r_used - CW'(1);
                            r_src        <= r_chk + AW'(1);
                            r_last       <= AW'(r_used - CW'(1));
                            r_up         <= 1'b0;
                            r_iss_done   <= 1'b0;
                            r_then_write <= 1'b0;
                        end
                    end else if (r_dv && (r_op == FUNC_FREE)) begin
                        if (w_f_next) begin
                            r_next     <= r_rdata;
                            r_has_next <= 1'b1;
                            r_pos      <= CW'(r_chk);
                        end else begin
                            r_prev     <= r_rdata;
                            r_has_prev <= 1'b1;
                        end
                    end else if (w_scan_end) begin
                        r_pos <= r_used;
                    end
                end
                S_JNEXT: begin
                    r_join_next <= w_jn;
                    r_merged    <= w_jn ? w_jn_sum[LEN_W-1:0] : r_len;
                end
                S_JPREV: begin
                    r_then_shift <= 1'b0;
                    if (w_jp) begin
                        r_wr_addr    <= AW'(r_pos - CW'(1));
                        r_wr_data    <= '{start: r_prev.start, len: w_jp_sum[LEN_W-1:0]};
                        r_then_shift <= w_rm_shift;
                        r_src        <= AW'(r_pos + CW'(1));
                        r_last       <= AW'(r_used - CW'(1));
                        r_up         <= 1'b0;
                        r_iss_done   <= 1'b0;
                        r_then_write <= 1'b0;
                        if (r_join_next) begin
                            r_used <= r_used - CW'(1);
                        end
                    end else if (r_join_next) begin
                        r_wr_addr <= AW'(r_pos);
                        r_wr_data <= '{start: r_page, len: r_merged};
                    end else if (w_full) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_wr_addr    <= AW'(r_pos);
                        r_wr_data    <= '{start: r_page, len: r_len};
                        r_used       <= r_used + CW'(1);
                        r_src        <= AW'(r_used - CW'(1));
                        r_last       <= AW'(r_pos);
                        r_up         <= 1'b1;
                        r_iss_done   <= 1'b0;
                        r_then_write <= 1'b1;
                    end
                end
                S_RESP: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= r_status;
                        r_o_granted <= r_granted;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_granted_page = r_o_granted;

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(MAX_EXTENTS))
        else $error("extent count exceeds table depth");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != S_IDLE)
        else $error("accepted word did not start work");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_NO_FIT
                         || o_status == ST_FULL))
        else $error("undefined status code");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> o_granted_page == '0)
        else $error("nonzero page on failed request");

endmodule
`default_nettype wire
